@@ hdl/hex_grid_wall_map_assert.svh @@
// Assertion macros for the hex grid wall map.
// Used by hex_grid_wall_map.sv; no other dependencies.
`ifndef HEX_GRID_WALL_MAP_ASSERT_SVH
`define HEX_GRID_WALL_MAP_ASSERT_SVH
`define HGW_ASSERT_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("hgw check failed");
`define HGW_ASSERT_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("hgw check failed");
`endif

@@ hdl/hgw_pkg.sv @@
// Package for the hex grid wall map: store sizes, modes, config register indices.
// No dependencies.
package hgw_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int Depth     = MaxWidth * MaxHeight;
  localparam int AW        = $clog2(Depth);
  localparam int XW        = $clog2(MaxWidth);
  localparam int YW        = $clog2(MaxHeight);
  localparam int CW        = AW + 1;
  localparam logic [6:0] AllWalls = 7'h3F;
  localparam logic [6:0] MarkBit  = 7'h40;
  localparam logic [2:0] MODE_INIT = 3'd0;
  localparam logic [2:0] MODE_WALL = 3'd1;
  localparam logic [2:0] MODE_MARK = 3'd2;
  localparam logic [2:0] MODE_MALL = 3'd3;
  localparam logic [2:0] MODE_OPEN = 3'd4;
  localparam logic [2:0] MODE_SHUT = 3'd5;
  localparam logic [2:0] MODE_READ = 3'd6;
  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;
  typedef logic [6:0] cell_t;
endpackage

@@ hdl/hex_grid_wall_map.sv @@
// Hex grid wall map top level: cell store, id divider, sequencer.
// Depends on hgw_pkg and hex_grid_wall_map_assert.svh.
//  channel | direction | handshake
//  in_     | in        | start & !busy
//  out_    | out       | out_strobe, one cycle, no stall
//  cfg_    | in        | cfg_valid & cfg_ready, ready only while idle and start low
// Reset: clearing pass over all 4096 cells, busy high.
// Each item: accept, divide (one width subtract a cycle, skipped for ids off grid);
// fill modes one cell a cycle; mark: read, wait, write; listing: read, wait, 6
// direction steps, final; wall: read, wait, up to 6 directions, writes both on a match.
// Results cannot be stalled; each appears the cycle after the step that makes it.
`include "hex_grid_wall_map_assert.svh"
module hex_grid_wall_map import hgw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_cell_a,
  input  logic [11:0] in_cell_b,
  input  logic        in_flag,
  output logic        out_strobe,
  output logic [11:0] out_neighbour_id,
  output logic        out_valid_res,
  output logic        out_is_marked,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_DIV = 4'd2, S_FILL = 4'd3,
    S_RDA = 4'd4, S_WAITA = 4'd5, S_DIR = 4'd6, S_WRA = 4'd7, S_RDB = 4'd8,
    S_WAITB = 4'd9, S_WRB = 4'd10, S_LAST = 4'd11;

  logic [3:0]  st_r, st_nxt;
  logic [6:0]  wcfg_r, hcfg_r;
  logic [2:0]  mode_r;
  logic [11:0] a_r, b_r, rem_r;
  logic        flag_r, any_r;
  logic [YW:0] ay_r;
  logic [2:0]  d_r;
  logic [AW-1:0] cnt_r;
  logic [CW-1:0] cells_r;
  cell_t       mem [Depth];
  cell_t       rd_r, cell_a_r;
  logic          we;
  logic [AW-1:0] wa, ra;
  cell_t         wd;
  logic          a_in;

  // mode 3 needs read-modify-write: read at cnt, write in the following cycle
  logic          mall_we_r;
  logic [AW-1:0] mall_a_r;
  logic          fill_rd;

  logic out_strobe_r, out_valid_r, out_mark_r, out_last_r;
  logic [11:0] out_id_r, hold_id_r;
  logic dir_hit;

  logic [XW:0] w; logic [YW:0] h;
  assign w = (wcfg_r == 7'd0) ? (XW+1)'(1) :
             (wcfg_r > 7'(MaxWidth)) ? (XW+1)'(MaxWidth) : (XW+1)'(wcfg_r);
  assign h = (hcfg_r == 7'd0) ? (YW+1)'(1) :
             (hcfg_r > 7'(MaxHeight)) ? (YW+1)'(MaxHeight) : (YW+1)'(hcfg_r);

  assign busy = (st_r != S_IDLE);
  assign cfg_ready = (st_r == S_IDLE) && !start;
  assign a_in = {1'b0, a_r} < cells_r;
  assign fill_rd = (st_r == S_FILL) && (mode_r == MODE_MALL);

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end

  // neighbour of (ax, ay) in direction d_r
  logic [XW:0] ax;
  logic signed [XW+1:0] nx;
  logic signed [YW+1:0] ny;
  logic [1:0] dyc;
  logic nb_ok;
  logic [11:0] nid;
  always_comb begin
    ax = rem_r[XW:0];
    case (d_r)
      3'd0: begin nx = '0; dyc = 2'd0; end
      3'd1: begin nx = {{(XW+1){1'b0}}, 1'b1}; dyc = ax[0] ? 2'd1 : 2'd0; end
      3'd2: begin nx = {{(XW+1){1'b0}}, 1'b1}; dyc = ax[0] ? 2'd2 : 2'd1; end
      3'd3: begin nx = '0; dyc = 2'd2; end
      3'd4: begin nx = '1; dyc = ax[0] ? 2'd2 : 2'd1; end
      default: begin nx = '1; dyc = ax[0] ? 2'd1 : 2'd0; end
    endcase
    nx = nx + $signed({1'b0, ax});
    ny = $signed({1'b0, ay_r}) + $signed({{YW{1'b0}}, dyc}) + '1;
    nb_ok = (nx >= 0) && (ny >= 0) && (nx < $signed({1'b0, w})) &&
            (ny < $signed({1'b0, h}));
    nid = 12'(ny[YW:0]) * 12'(w) + 12'(nx[XW:0]);
  end

  logic [2:0] dop;
  assign dop = (d_r >= 3'd3) ? d_r - 3'd3 : d_r + 3'd3;

  always_comb begin
    st_nxt = st_r;
    we = 1'b0; wa = cnt_r; wd = AllWalls; ra = a_r[AW-1:0];
    case (st_r)
      S_CLR: begin we = 1'b1; if (&cnt_r) st_nxt = S_IDLE; end
      S_IDLE: if (start) st_nxt = S_DIV;
      S_DIV: if (rem_r < 12'(w) || !a_in) begin
        case (mode_r)
          MODE_INIT, MODE_MALL: st_nxt = S_FILL;
          MODE_WALL, MODE_MARK: st_nxt = a_in ? S_RDA : S_IDLE;
          MODE_OPEN, MODE_SHUT, MODE_READ: st_nxt = a_in ? S_RDA : S_LAST;
          default: st_nxt = S_IDLE;
        endcase
      end
      S_FILL: begin
        ra = cnt_r;
        we = (mode_r == MODE_INIT);
        wd = AllWalls;
        if (CW'(cnt_r) + 1'b1 == cells_r) st_nxt = S_IDLE;
      end
      S_RDA: st_nxt = S_WAITA;
      S_WAITA: begin
        case (mode_r)
          MODE_MARK: st_nxt = S_WRA;
          MODE_READ: st_nxt = S_LAST;
          default: st_nxt = S_DIR;
        endcase
      end
      S_DIR: begin
        if (mode_r == MODE_WALL) begin
          if (nb_ok && nid == b_r)
            st_nxt = S_WRA;
          else if (d_r == 3'd5) st_nxt = S_IDLE;
        end else if (d_r == 3'd5) st_nxt = S_LAST;
      end
      S_WRA: begin
        we = 1'b1; wa = a_r[AW-1:0];
        if (mode_r == MODE_MARK) begin
          wd = flag_r ? (cell_a_r | MarkBit) : (cell_a_r & ~MarkBit);
          st_nxt = S_IDLE;
        end else begin
          wd = flag_r ? (cell_a_r | cell_t'(7'd1 << d_r)) :
                        (cell_a_r & ~cell_t'(7'd1 << d_r));
          st_nxt = S_RDB;
        end
      end
      S_RDB: begin ra = b_r[AW-1:0]; st_nxt = S_WAITB; end
      S_WAITB: begin ra = b_r[AW-1:0]; st_nxt = S_WRB; end
      S_WRB: begin
        we = 1'b1; wa = b_r[AW-1:0];
        wd = flag_r ? (rd_r | cell_t'(7'd1 << dop)) : (rd_r & ~cell_t'(7'd1 << dop));
        st_nxt = S_IDLE;
      end
      S_LAST: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (mall_we_r) begin
      we = 1'b1; wa = mall_a_r;
      wd = flag_r ? (rd_r | MarkBit) : (rd_r & ~MarkBit);
    end
  end

  assign dir_hit = nb_ok && (cell_a_r[d_r] == (mode_r == MODE_SHUT));

  // a listed neighbour is held until the next one or the final step, so the final one can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; wcfg_r <= 7'd64; hcfg_r <= 7'd64;
      out_strobe_r <= 1'b0; mall_we_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_strobe_r <= (st_r == S_LAST) ||
                      ((st_r == S_DIR) && (mode_r != MODE_WALL) && dir_hit && any_r);
      mall_we_r <= fill_rd;
      mall_a_r <= cnt_r;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) wcfg_r <= cfg_data;
        else hcfg_r <= cfg_data;
      end
      case (st_r)
        S_CLR: cnt_r <= cnt_r + 1'b1;
        S_IDLE: if (start) begin
          mode_r <= in_mode; a_r <= in_cell_a; b_r <= in_cell_b; flag_r <= in_flag;
          rem_r <= in_cell_a; ay_r <= '0; cnt_r <= '0; d_r <= '0; any_r <= 1'b0;
          cells_r <= CW'(w) * CW'(h);
        end
        S_DIV: if (rem_r >= 12'(w)) begin
          rem_r <= rem_r - 12'(w); ay_r <= ay_r + 1'b1;
        end
        S_FILL: cnt_r <= cnt_r + 1'b1;
        S_WAITA: cell_a_r <= rd_r;
        S_DIR: begin
          if (!(mode_r == MODE_WALL && st_nxt == S_WRA)) d_r <= d_r + 1'b1;
          if (mode_r != MODE_WALL && dir_hit) begin
            out_id_r <= hold_id_r; out_valid_r <= 1'b1;
            out_mark_r <= 1'b0; out_last_r <= 1'b0;
            hold_id_r <= nid; any_r <= 1'b1;
          end
        end
        S_LAST: begin
          out_id_r <= any_r ? hold_id_r : 12'd0; out_valid_r <= any_r;
          out_last_r <= 1'b1;
          out_mark_r <= (mode_r == MODE_READ) && a_in && cell_a_r[6];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_strobe = out_strobe_r; out_neighbour_id = out_id_r; out_valid_res = out_valid_r;
    out_is_marked = out_mark_r; out_last = out_last_r;
  end

  `HGW_ASSERT_IMPL(a_idle_quiet, (st_r == S_IDLE) && $past(st_r) == S_IDLE, !out_strobe)
  `HGW_ASSERT_NEXT(a_last_idle, out_strobe && out_last, !busy || st_r == S_DIV)
  `HGW_ASSERT_IMPL(a_valid_id, out_strobe && !out_valid_res, out_neighbour_id == 12'd0)
endmodule

@@ tb/sv/hex_grid_wall_map_check.sv @@
// Checker for the hex grid wall map: tracks config and cell store, predicts results.
// Watches the in_, out_ and cfg_ channels; depends on hgw_pkg.
module hex_grid_wall_map_check import hgw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        busy,
  input  logic [2:0]  in_mode,
  input  logic [11:0] in_cell_a,
  input  logic [11:0] in_cell_b,
  input  logic        in_flag,
  input  logic        out_strobe,
  input  logic [11:0] out_neighbour_id,
  input  logic        out_valid_res,
  input  logic        out_is_marked,
  input  logic        out_last,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  output int          errors,
  output int          pending
);
  typedef struct packed {
    logic [11:0] nid;
    logic        vld;
    logic        mk;
    logic        lst;
  } nbr_result_t;

  nbr_result_t expected_q[$];
  cell_t       cells[Depth];
  logic [6:0]  width_reg, height_reg;

  initial begin
    errors = 0;
    width_reg = 7'd64;
    height_reg = 7'd64;
    for (int i = 0; i < Depth; i++) cells[i] = AllWalls;
  end

  assign pending = expected_q.size();

  function automatic int clamp_dim(logic [6:0] v, int lim);
    if (v == 0) return 1;
    if (int'(v) > lim) return lim;
    return int'(v);
  endfunction

  function automatic bit hex_step(int x, int y, int d, int w, int h, output int id);
    int dx[6] = '{0, 1, 1, 0, -1, -1};
    int dy_even[6] = '{-1, -1, 0, 1, 0, -1};
    int dy_odd[6] = '{-1, 0, 1, 1, 1, 0};
    int nx, ny;
    nx = x + dx[d];
    ny = y + ((x % 2 == 0) ? dy_even[d] : dy_odd[d]);
    id = 0;
    if (nx < 0 || ny < 0 || nx >= w || ny >= h) return 0;
    id = ny * w + nx;
    return 1;
  endfunction

  task automatic predict_request(logic [2:0] mode, int a, int b, logic flag);
    int w, h, n, x, y, nid, cnt;
    nbr_result_t r;
    w = clamp_dim(width_reg, MaxWidth);
    h = clamp_dim(height_reg, MaxHeight);
    n = w * h;
    x = a % w;
    y = a / w;
    cnt = 0;
    case (mode)
      MODE_INIT: for (int i = 0; i < n; i++) cells[i] = AllWalls;
      MODE_WALL: begin
        if (a < n && b < n) begin
          for (int d = 0; d < 6; d++) begin
            if (hex_step(x, y, d, w, h, nid) && nid == b) begin
              cells[a][d] = flag;
              cells[b][(d + 3) % 6] = flag;
              break;
            end
          end
        end
      end
      MODE_MARK: if (a < n) cells[a][6] = flag;
      MODE_MALL: for (int i = 0; i < n; i++) cells[i][6] = flag;
      MODE_OPEN, MODE_SHUT: begin
        if (a < n) begin
          for (int d = 0; d < 6; d++) begin
            if (cells[a][d] != (mode == MODE_SHUT)) continue;
            if (!hex_step(x, y, d, w, h, nid)) continue;
            r = '{nid: nid[11:0], vld: 1'b1, mk: 1'b0, lst: 1'b0};
            expected_q.insert(expected_q.size(), r);
            cnt++;
          end
        end
        if (cnt == 0) begin
          r = '{nid: 12'd0, vld: 1'b0, mk: 1'b0, lst: 1'b1};
          expected_q.insert(expected_q.size(), r);
        end else expected_q[expected_q.size() - 1].lst = 1'b1;
      end
      MODE_READ: begin
        r = '{nid: 12'd0, vld: 1'b0, mk: (a < n) ? cells[a][6] : 1'b0, lst: 1'b1};
        expected_q.insert(expected_q.size(), r);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    nbr_result_t e;
    if (rst_n) begin
      if (out_strobe) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result nid=%0d valid=%0b marked=%0b last=%0b", $time,
                   out_neighbour_id, out_valid_res, out_is_marked, out_last);
        end else begin
          e = expected_q.pop_front();
          if (out_neighbour_id !== e.nid || out_valid_res !== e.vld ||
              out_is_marked !== e.mk || out_last !== e.lst) begin
            errors++;
            $display("%0t: mismatch expected nid=%0d valid=%0b marked=%0b last=%0b",
                     $time, e.nid, e.vld, e.mk, e.lst);
            $display("%0t:          actual   nid=%0d valid=%0b marked=%0b last=%0b",
                     $time, out_neighbour_id, out_valid_res, out_is_marked, out_last);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WIDTH) width_reg = cfg_data;
        else height_reg = cfg_data;
      end
      if (start && !busy) predict_request(in_mode, in_cell_a, in_cell_b, in_flag);
    end
  end
endmodule

@@ tb/sv/hex_grid_wall_map_test.sv @@
// Testbench top for the hex grid wall map: clock, reset, directed and random requests.
// Depends on hgw_pkg, hex_grid_wall_map and hex_grid_wall_map_check.
module hex_grid_wall_map_test import hgw_pkg::*;;
  logic        clk, rst_n, start, busy;
  logic [2:0]  in_mode;
  logic [11:0] in_cell_a, in_cell_b;
  logic        in_flag;
  logic        out_strobe, out_valid_res, out_is_marked, out_last;
  logic [11:0] out_neighbour_id;
  logic        cfg_valid, cfg_ready, cfg_index;
  logic [6:0]  cfg_data;
  int          errors, pending;
  int          cur_w, cur_h;

  hex_grid_wall_map i_dut (.*);
  hex_grid_wall_map_check i_check (.*);

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  initial begin
    #4000000;
    $display("hex_grid_wall_map_test NOT OK");
    $finish;
  end

  task automatic send_request(logic [2:0] m, logic [11:0] a, logic [11:0] b, logic f);
    start <= 1'b1;
    in_mode <= m;
    in_cell_a <= a;
    in_cell_b <= b;
    in_flag <= f;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_grid(logic [6:0] w, logic [6:0] h);
    drain();
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    cfg_valid <= 1'b0;
    cur_w = (w == 0) ? 1 : (w > MaxWidth) ? MaxWidth : w;
    cur_h = (h == 0) ? 1 : (h > MaxHeight) ? MaxHeight : h;
  endtask

  task automatic random_phase(int count);
    int r, n, a, b, burst;
    logic [2:0] m;
    int offs[8];
    n = cur_w * cur_h;
    offs = '{-cur_w - 1, -cur_w, -cur_w + 1, -1, 1, cur_w - 1, cur_w, cur_w + 1};
    burst = $urandom_range(1, 8);
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      a = ($urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1) : $urandom_range(0, 4095);
      b = ($urandom_range(0, 9) < 8) ? (a + offs[$urandom_range(0, 7)]) & 12'hFFF
                                    : $urandom_range(0, 4095);
      if (r < 35) m = MODE_WALL;
      else if (r < 50) m = MODE_OPEN;
      else if (r < 60) m = MODE_SHUT;
      else if (r < 70) m = MODE_MARK;
      else if (r < 82) m = MODE_READ;
      else if (r < 87) m = (n <= 256) ? MODE_MALL : MODE_READ;
      else if (r < 90) m = (n <= 256) ? MODE_INIT : MODE_OPEN;
      else if (r < 93) m = 3'd7;
      else m = MODE_OPEN;
      send_request(m, a[11:0], b[11:0], $urandom_range(0, 1));
      if (--burst == 0) begin
        if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 20));
        burst = $urandom_range(1, 8);
      end
    end
  endtask

  initial begin
    logic [6:0] ws[8];
    logic [6:0] hs[8];
    ws = '{7'd5, 7'd1, 7'd0, 7'd127, 7'd2, 7'd7, 7'd64, 7'd9};
    hs = '{7'd3, 7'd1, 7'd64, 7'd0, 7'd127, 7'd9, 7'd1, 7'd4};
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_READ;
    in_cell_a = '0;
    in_cell_b = '0;
    in_flag = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WIDTH;
    cfg_data = '0;
    cur_w = 64;
    cur_h = 64;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_grid(7'd64, 7'd64);
    send_request(MODE_READ, 12'd0, 12'd0, 1'b0);
    send_request(MODE_OPEN, 12'd0, 12'd0, 1'b0);
    send_request(MODE_SHUT, 12'd0, 12'd0, 1'b0);
    send_request(MODE_SHUT, 12'd4095, 12'd4095, 1'b1);
    send_request(MODE_WALL, 12'd0, 12'd1, 1'b0);
    send_request(MODE_OPEN, 12'd0, 12'd0, 1'b0);
    send_request(MODE_OPEN, 12'd1, 12'd0, 1'b0);
    send_request(MODE_WALL, 12'd0, 12'd1, 1'b1);
    send_request(MODE_WALL, 12'd5, 12'd5, 1'b0);
    send_request(MODE_WALL, 12'd0, 12'd4095, 1'b0);
    send_request(MODE_WALL, 12'd200, 12'd264, 1'b0);
    send_request(MODE_SHUT, 12'd200, 12'd0, 1'b0);
    send_request(MODE_MARK, 12'd4095, 12'd0, 1'b1);
    send_request(MODE_READ, 12'd4095, 12'd0, 1'b0);
    send_request(MODE_MALL, 12'd0, 12'd0, 1'b1);
    send_request(MODE_READ, 12'd2730, 12'd1365, 1'b0);
    send_request(MODE_MALL, 12'd0, 12'd0, 1'b0);
    send_request(MODE_INIT, 12'd0, 12'd0, 1'b0);
    send_request(3'd7, 12'd0, 12'd0, 1'b1);
    send_request(MODE_READ, 12'd63, 12'd0, 1'b0);
    set_grid(7'd5, 7'd3);
    send_request(MODE_MARK, 12'd20, 12'd0, 1'b1);
    send_request(MODE_READ, 12'd20, 12'd0, 1'b0);
    send_request(MODE_SHUT, 12'd20, 12'd0, 1'b0);
    send_request(MODE_OPEN, 12'd4095, 12'd0, 1'b0);
    send_request(MODE_WALL, 12'd14, 12'd20, 1'b0);

    for (int p = 0; p < 8; p++) begin
      if (p == 3) drain();
      set_grid(ws[p], hs[p]);
      random_phase(13);
    end

    drain();
    if (errors == 0 && pending == 0) $display("hex_grid_wall_map_test OK");
    else $display("hex_grid_wall_map_test NOT OK");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hdl
hdl/hgw_pkg.sv
hdl/hex_grid_wall_map.sv
tb/sv/hex_grid_wall_map_check.sv
tb/sv/hex_grid_wall_map_test.sv
